// ===== rtl/scps_pkg.sv =====
`timescale 1ns / 1ps

package scps_pkg;

	// fixed field widths
	localparam int IDX_W  = 10;
	localparam int RES_W  = 11;
	localparam int POS_W  = 16;
	localparam int BAND_W = 2;
	localparam int RGB_W  = 8;

	// configuration port
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_RES = REG_IDX_W'(0);
	localparam logic [RES_W-1:0] SAMPLE_RES_RESET = RES_W'(256);

	// parameter defaults
	localparam int MAX_RES_DEF         = 1024;
	localparam int COORD_FRAC_BITS_DEF = 14;

	// star geometry
	localparam int NUM_VERTS = 5;
	localparam int NUM_TRIS  = 5;
	localparam int NUM_EDGES = 3 * NUM_TRIS;

	typedef logic signed [127:0] wide_t;
	typedef logic [BAND_W-1:0] band_t;

	// colour per radius band
	localparam logic [RGB_W-1:0] BAND_RED   [4] = '{8'd61, 8'd245, 8'd90,  8'd245};
	localparam logic [RGB_W-1:0] BAND_GREEN [4] = '{8'd6,  8'd237, 8'd196, 8'd237};
	localparam logic [RGB_W-1:0] BAND_BLUE  [4] = '{8'd22, 8'd224, 8'd104, 8'd224};

	// outer vertices in Q30
	function automatic wide_t q30_x(input int k);
		wide_t v;
		unique case (k)
			0:       v = 128'sd0;
			1:       v = 128'sd1021189159;
			2:       v = 128'sd631129609;
			3:       v = -128'sd631129609;
			default: v = -128'sd1021189159;
		endcase
		return v;
	endfunction

	function automatic wide_t q30_y(input int k);
		wide_t v;
		unique case (k)
			0:       v = 128'sd1073741824;
			1:       v = 128'sd331804471;
			2:       v = -128'sd868675383;
			3:       v = -128'sd868675383;
			default: v = 128'sd331804471;
		endcase
		return v;
	endfunction

	// round Q30 to f fraction bits, ties away from zero
	function automatic wide_t from_q30(input wide_t v, input int f);
		int    sh;
		wide_t mag;
		sh  = 30 - f;
		mag = (v < 0) ? -v : v;
		if (sh > 0)
			mag = (mag + (wide_t'(1) <<< (sh - 1))) >>> sh;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic wide_t vert(input int k, input int f, input bit is_y);
		return is_y ? from_q30(q30_y(k), f) : from_q30(q30_x(k), f);
	endfunction

	// point at four times scale: ids 0..4 outer vertices, 5..9 inner points
	function automatic wide_t pt(input int id, input int f, input bit is_y);
		wide_t sum;
		sum = '0;
		for (int k = 0; k < NUM_VERTS; k++)
			sum = sum + vert(k, f, is_y);
		if (id < NUM_VERTS)
			return 4 * vert(id, f, is_y);
		return sum - vert(id - NUM_VERTS, f, is_y);
	endfunction

	// edge endpoints: triangle t joins vertex t, vertex t+2 and inner point t+1
	function automatic int edge_pt(input int e, input bit second);
		int t;
		int s;
		int i;
		int j;
		int o;
		t = e / 3;
		s = e % 3;
		i = t;
		j = (t + 2) % NUM_VERTS;
		o = NUM_VERTS + (t + 1) % NUM_VERTS;
		if (s == 0)
			return second ? j : i;
		if (s == 1)
			return second ? o : j;
		return second ? i : o;
	endfunction

	// edge function E = ka*x + kb*y + kc at four times scale
	function automatic wide_t edge_ka(input int e, input int f);
		return 4 * (pt(edge_pt(e, 1'b1), f, 1'b1) - pt(edge_pt(e, 1'b0), f, 1'b1));
	endfunction

	function automatic wide_t edge_kb(input int e, input int f);
		return -4 * (pt(edge_pt(e, 1'b1), f, 1'b0) - pt(edge_pt(e, 1'b0), f, 1'b0));
	endfunction

	function automatic wide_t edge_kc(input int e, input int f);
		wide_t ax;
		wide_t ay;
		wide_t bx;
		wide_t by;
		ax = pt(edge_pt(e, 1'b0), f, 1'b0);
		ay = pt(edge_pt(e, 1'b0), f, 1'b1);
		bx = pt(edge_pt(e, 1'b1), f, 1'b0);
		by = pt(edge_pt(e, 1'b1), f, 1'b1);
		return ay * (bx - ax) - ax * (by - ay);
	endfunction

endpackage

// ===== rtl/scps_div.sv =====
`timescale 1ns / 1ps

module scps_div #(
	parameter int NW = 26,
	parameter int DW = 11,
	parameter int QW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          vld_out,
	output logic [QW-1:0] quo
);

	localparam int TW = (NW > DW + QW) ? NW : DW + QW;

	logic [TW-1:0] rem_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [QW-1:0] vld_s;

	// one quotient bit per stage, most significant first
	for (genvar n = 0; n < QW; n++) begin : g_stage
		logic [TW-1:0] rem_in;
		logic [QW-1:0] quo_in;
		logic          vld_in_n;
		logic [TW-1:0] trial;

		if (n == 0) begin : g_first
			assign rem_in   = TW'(num);
			assign quo_in   = '0;
			assign vld_in_n = vld_in;
		end else begin : g_next
			assign rem_in   = rem_s[n-1];
			assign quo_in   = quo_s[n-1];
			assign vld_in_n = vld_s[n-1];
		end

		assign trial = TW'(den) << (QW - 1 - n);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[n] <= 1'b0;
			end else begin
				vld_s[n] <= vld_in_n;
			end
		end

		// restoring subtract step
		always_ff @(posedge clk) begin
			if (rem_in >= trial) begin
				rem_s[n] <= rem_in - trial;
				quo_s[n] <= quo_in | (QW'(1) << (QW - 1 - n));
			end else begin
				rem_s[n] <= rem_in;
				quo_s[n] <= quo_in;
			end
		end
	end

	assign vld_out = vld_s[QW-1];
	assign quo     = quo_s[QW-1];

endmodule

// ===== rtl/scps_star.sv =====
`timescale 1ns / 1ps

module scps_star
	import scps_pkg::*;
#(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                vld,
	input  logic signed [COORD_FRAC_BITS+1:0]   x,
	input  logic signed [COORD_FRAC_BITS+1:0]   y,
	output logic                                done,
	output logic signed [POS_W-1:0]             pos_x,
	output logic signed [POS_W-1:0]             pos_y,
	output band_t                               color_band,
	output logic [RGB_W-1:0]                    red,
	output logic [RGB_W-1:0]                    green,
	output logic [RGB_W-1:0]                    blue
);

	localparam int F   = COORD_FRAC_BITS;
	localparam int CW  = F + 2;
	localparam int KW  = F + 6;
	localparam int PW  = 2 * F + 8;
	localparam int EW  = 2 * F + 10;
	localparam int R2W = 2 * F + 5;

	localparam logic [R2W-1:0] TH_1 = R2W'(1) << (2 * F - 4);
	localparam logic [R2W-1:0] TH_2 = R2W'(4) << (2 * F - 4);
	localparam logic [R2W-1:0] TH_3 = R2W'(9) << (2 * F - 4);

	logic                   vld_s1;
	logic                   vld_s2;
	logic                   vld_s3;
	logic signed [CW-1:0]   x_s1;
	logic signed [CW-1:0]   y_s1;
	logic signed [CW-1:0]   x_s2;
	logic signed [CW-1:0]   y_s2;
	logic signed [PW-1:0]   pa_s1 [NUM_EDGES];
	logic signed [PW-1:0]   pb_s1 [NUM_EDGES];
	logic [R2W-1:0]         xx_s1;
	logic [R2W-1:0]         yy_s1;
	logic [NUM_EDGES-1:0]   neg_s2;
	logic [NUM_EDGES-1:0]   pos_s2;
	band_t                  band_s2;
	logic [R2W-1:0]         r2;
	logic [NUM_TRIS-1:0]    tri_hit;
	logic signed [R2W-1:0]  sq_x;
	logic signed [R2W-1:0]  sq_y;

	// one lane per edge: constant multiplies, then sum and sign
	for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
		localparam logic signed [KW-1:0] KA = KW'(edge_ka(e, F));
		localparam logic signed [KW-1:0] KB = KW'(edge_kb(e, F));
		localparam logic signed [EW-1:0] KC = EW'(edge_kc(e, F));
		logic signed [EW-1:0] esum;

		always_ff @(posedge clk) begin
			pa_s1[e] <= PW'(x) * PW'(KA);
			pb_s1[e] <= PW'(y) * PW'(KB);
		end

		assign esum = EW'(pa_s1[e]) + EW'(pb_s1[e]) + KC;

		always_ff @(posedge clk) begin
			neg_s2[e] <= esum[EW-1];
			pos_s2[e] <= !esum[EW-1] && (esum != '0);
		end
	end

	// squared radius terms
	assign sq_x = R2W'(x) * R2W'(x);
	assign sq_y = R2W'(y) * R2W'(y);
	assign r2   = xx_s1 + yy_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2 && (|tri_hit);
		end
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		x_s1  <= x;
		y_s1  <= y;
		xx_s1 <= $unsigned(sq_x);
		yy_s1 <= $unsigned(sq_y);
	end

	// stage 2: radius band
	always_ff @(posedge clk) begin
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		priority if (r2 < TH_1) begin
			band_s2 <= band_t'(0);
		end else if (r2 < TH_2) begin
			band_s2 <= band_t'(1);
		end else if (r2 < TH_3) begin
			band_s2 <= band_t'(2);
		end else begin
			band_s2 <= band_t'(3);
		end
	end

	// a triangle holds the point unless its edges disagree in sign
	always_comb begin
		for (int t = 0; t < NUM_TRIS; t++)
			tri_hit[t] = !((neg_s2[3*t] || neg_s2[3*t+1] || neg_s2[3*t+2]) &&
				(pos_s2[3*t] || pos_s2[3*t+1] || pos_s2[3*t+2]));
	end

	// stage 3: result register
	always_ff @(posedge clk) begin
		pos_x      <= POS_W'(x_s2);
		pos_y      <= POS_W'(y_s2);
		color_band <= band_s2;
		red        <= BAND_RED[band_s2];
		green      <= BAND_GREEN[band_s2];
		blue       <= BAND_BLUE[band_s2];
	end

	assign done = vld_s3;

endmodule

// ===== rtl/star_coverage_point_sampler_unit.sv =====
`timescale 1ns / 1ps

// channel   | ports                                          | handshake
// ----------+------------------------------------------------+------------------------------
// request   | col_index, row_index                           | start while busy low
// result    | pos_x, pos_y, color_band, red, green, blue     | done, one cycle, no stall
// config    | psel, penable, pwrite, paddr, pwdata, prdata   | apb, pready tied high
//
// one request per cycle; busy stays low, the pipeline never holds off
// the pipeline is an input register, one stage per quotient bit of the
// coordinate divider, then three geometry stages
// requests outside the grid or outside the star produce no result
// arst_n clears valid bits and sets sample_res to 256

module star_coverage_point_sampler_unit
	import scps_pkg::*;
#(
	parameter int MAX_RES         = MAX_RES_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [IDX_W-1:0]         col_index,
	input  logic [IDX_W-1:0]         row_index,
	output logic                     done,
	output logic signed [POS_W-1:0]  pos_x,
	output logic signed [POS_W-1:0]  pos_y,
	output band_t                    color_band,
	output logic [RGB_W-1:0]         red,
	output logic [RGB_W-1:0]         green,
	output logic [RGB_W-1:0]         blue,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	localparam int F      = COORD_FRAC_BITS;
	localparam int CW     = F + 2;
	localparam int QW     = F + 2;
	localparam int NW     = IDX_W + F + 2;
	localparam int RES_HI = (MAX_RES > (1 << RES_W) - 1) ? (1 << RES_W) - 1 : MAX_RES;

	logic [RES_W-1:0] sample_res_q;
	logic [RES_W-1:0] res_eff;
	logic [RES_W-1:0] den;
	logic             in_range;
	logic             vld_s1;
	logic [NW-1:0]    num_x_s1;
	logic [NW-1:0]    num_y_s1;
	logic             vld_x;
	logic             vld_y;
	logic [QW-1:0]    quo_x;
	logic [QW-1:0]    quo_y;
	logic signed [CW-1:0] coord_x;
	logic signed [CW-1:0] coord_y;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_res_q <= SAMPLE_RES_RESET;
		end else if (psel && penable && pwrite && pready &&
			paddr[ADDR_W-1:2] == REG_SAMPLE_RES) begin
			sample_res_q <= pwdata[RES_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1:2] == REG_SAMPLE_RES) ? DATA_W'(sample_res_q) : '0;

	// clamp resolution to the supported range
	always_comb begin
		priority if (sample_res_q < RES_W'(2)) begin
			res_eff = RES_W'(2);
		end else if (sample_res_q > RES_W'(RES_HI)) begin
			res_eff = RES_W'(RES_HI);
		end else begin
			res_eff = sample_res_q;
		end
	end

	assign den      = res_eff - RES_W'(1);
	assign in_range = (RES_W'(col_index) < res_eff) && (RES_W'(row_index) < res_eff);
	assign busy     = 1'b0;

	// input stage: dividend with half divisor for round to nearest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy && in_range;
		end
	end

	always_ff @(posedge clk) begin
		num_x_s1 <= (NW'(col_index) << (F + 1)) + NW'(den >> 1);
		num_y_s1 <= (NW'(row_index) << (F + 1)) + NW'(den >> 1);
	end

	// grid index to coordinate, one divider per axis
	scps_div #(
		.NW(NW),
		.DW(RES_W),
		.QW(QW)
	) u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s1),
		.num     (num_x_s1),
		.den     (den),
		.vld_out (vld_x),
		.quo     (quo_x)
	);

	scps_div #(
		.NW(NW),
		.DW(RES_W),
		.QW(QW)
	) u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s1),
		.num     (num_y_s1),
		.den     (den),
		.vld_out (vld_y),
		.quo     (quo_y)
	);

	// both dividers run in lockstep
	assign coord_x = $signed(quo_x) - $signed(CW'(1) << F);
	assign coord_y = $signed(quo_y) - $signed(CW'(1) << F);

	scps_star #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_star (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld        (vld_x && vld_y),
		.x          (coord_x),
		.y          (coord_y),
		.done       (done),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.color_band (color_band),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

endmodule
